/* design/f32add_pkg.sv */
// shared types and constants for the single-precision adder
`default_nettype none
package f32add_pkg;
   localparam int unsigned WordWidth = 32;
   localparam int unsigned ExpWidth = 8;
   localparam int unsigned FracWidth = 23;
   localparam int unsigned SigWidth = 25;
   localparam int unsigned ShiftWidth = 5;
   localparam logic [ShiftWidth-1:0] AlignCap = 5'd24;
   localparam logic [ExpWidth-1:0] ExpMax = 8'd254;
   localparam logic [ExpWidth-1:0] ExpAllOnes = 8'hff;

   // aligned operands after stage one
   typedef struct packed {
      logic sign;
      logic sub;
      logic [ExpWidth-1:0] exp;
      logic [SigWidth-1:0] sig_big;
      logic [SigWidth-1:0] sig_small;
   } align_type;

   // raw sum after stage two
   typedef struct packed {
      logic sign;
      logic [ExpWidth-1:0] exp;
      logic [SigWidth-1:0] sig;
   } sum_type;
endpackage
`default_nettype wire

/* design/f32add_align.sv */
// stage one: operand swap, exponent difference and significand alignment
`default_nettype none
module f32add_align (
   input  wire logic [31:0] a_bits,
   input  wire logic [31:0] b_bits,
   output f32add_pkg::align_type align
);
   import f32add_pkg::*;

   logic [WordWidth-1:0] big;
   logic [WordWidth-1:0] sml;
   logic [ExpWidth:0] diff;
   logic [ShiftWidth-1:0] shamt;
   logic [SigWidth-1:0] msmall;

   always_comb begin
      if (a_bits[30:0] < b_bits[30:0]) begin
         big = b_bits;
         sml = a_bits;
      end else begin
         big = a_bits;
         sml = b_bits;
      end
      // big magnitude implies big exponent, so diff is non-negative
      diff = {1'b0, big[30:23]} - {1'b0, sml[30:23]};
      if (diff > {4'd0, AlignCap}) shamt = AlignCap;
      else shamt = diff[ShiftWidth-1:0];
      msmall = {2'b01, sml[FracWidth-1:0]} >> shamt;
      align.sign = big[31];
      align.sub = big[31] ^ sml[31];
      align.exp = big[30:23];
      align.sig_big = {2'b01, big[FracWidth-1:0]};
      align.sig_small = msmall;
   end
endmodule
`default_nettype wire

/* design/f32add_norm.sv */
// stage three: leading-zero count, normalization and exponent repair
`default_nettype none
module f32add_norm (
   input  wire f32add_pkg::sum_type sum,
   output logic [31:0] sum_bits
);
   import f32add_pkg::*;

   logic [4:0] lz;
   logic [SigWidth-1:0] sig_n;
   logic [ExpWidth+1:0] exp_n;

   always_comb begin
      // position of leading one within the 25-bit raw sum
      lz = 5'd0;
      for (int i = 0; i < SigWidth; i++) begin
         if (sum.sig[i]) lz = 5'(SigWidth - 1 - i);
      end
      if (lz == 5'd0) begin
         sig_n = sum.sig >> 1;
         exp_n = {2'b00, sum.exp} + 10'd1;
      end else begin
         sig_n = sum.sig << (lz - 5'd1);
         exp_n = {2'b00, sum.exp} - 10'(lz - 5'd1);
      end
      if (sum.sig == '0) sum_bits = '0;
      else if (!exp_n[9] && exp_n[8:0] > {1'b0, ExpMax})
         sum_bits = {sum.sign, ExpAllOnes, 23'd0};
      else if (exp_n[9] || exp_n == '0) sum_bits = {sum.sign, 31'd0};
      else sum_bits = {sum.sign, exp_n[ExpWidth-1:0], sig_n[FracWidth-1:0]};
   end
endmodule
`default_nettype wire

/* design/float32_adder_core.sv */
// top level of the pipelined single-precision adder
`default_nettype none
// Three-stage pipelined float32 adder: takes one operand pair per cycle while
// the output is not stalled and carries each sum through s1_ff, s2_ff and
// s3_ff. Stage one swaps and aligns, stage two adds or subtracts the
// significands, stage three normalizes and repairs the exponent. Results are
// truncated; exact cancellation gives +0, overflow a signed infinity,
// underflow a signed zero. No NaN, infinity or denormal handling. The whole
// pipeline advances only when the output register is free or being taken,
// so a stall at the output holds every stage.
module float32_adder_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [31:0] req_a_bits,
   input  wire logic [31:0] req_b_bits,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [31:0] rsp_sum_bits
);
   import f32add_pkg::*;

   logic advance;
   logic v1_ff, v2_ff, v3_ff;
   align_type s1_ff, s1_in;
   sum_type s2_ff, s2_in;
   logic [WordWidth-1:0] s3_ff, s3_in;

   // pipeline moves when the last stage is empty or being drained
   assign advance = !v3_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = v3_ff;
   assign rsp_sum_bits = s3_ff;

   f32add_align u_align (.a_bits(req_a_bits), .b_bits(req_b_bits), .align(s1_in));

   // stage two: significand add or subtract
   always_comb begin
      s2_in.sign = s1_ff.sign;
      s2_in.exp = s1_ff.exp;
      if (s1_ff.sub) s2_in.sig = s1_ff.sig_big - s1_ff.sig_small;
      else s2_in.sig = s1_ff.sig_big + s1_ff.sig_small;
   end

   f32add_norm u_norm (.sum(s2_ff), .sum_bits(s3_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   // a stalled result must not change
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum_bits))
      else $error("stalled result changed");
   // while stalled no transfer is taken
   assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rsp_ready |-> !req_ready)
      else $error("input taken during stall");
   // an accepted item reaches the output through s1_ff, s2_ff and s3_ff while the output does not stall
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("item lost in pipeline");
endmodule
`default_nettype wire

/* tb/tb_float32_adder_core.sv */
// self-checking testbench for the pipelined single-precision adder
`default_nettype none

// keeps the expected sums in order and compares arriving ones against them
class sum_scoreboard;
   logic [31:0] pending_sums[$];
   int errors = 0;

   // truncating float add built from integer steps
   function automatic logic [31:0] add_f32(logic [31:0] x, logic [31:0] y);
      logic [31:0] big, lesser, sig_big, sig_small;
      logic sign;
      int exp_big, exp_small, shift, lz;
      big = x;
      lesser = y;
      if (x[30:0] < y[30:0]) begin
         big = y;
         lesser = x;
      end
      sign = big[31];
      exp_big = big[30:23];
      exp_small = lesser[30:23];
      sig_big = {9'b1, big[22:0]};
      sig_small = {9'b1, lesser[22:0]};
      shift = exp_big - exp_small;
      if (shift > 24) shift = 24;
      if (shift < 0) shift = 0;
      sig_small = sig_small >> shift;
      if (big[31] != lesser[31]) sig_big = sig_big - sig_small;
      else sig_big = sig_big + sig_small;
      if (sig_big == 0) return 32'h0;
      lz = 0;
      while (!sig_big[31 - lz]) lz++;
      if (lz <= 8) begin
         sig_big = sig_big >> (8 - lz);
         exp_big = exp_big + 8 - lz;
      end else begin
         sig_big = sig_big << (lz - 8);
         exp_big = exp_big - (lz - 8);
      end
      if (exp_big > 254) return {sign, 31'h7f800000};
      if (exp_big < 1) return {sign, 31'h0};
      return {sign, exp_big[7:0], sig_big[22:0]};
   endfunction

   function void note_operands(logic [31:0] a, logic [31:0] b);
      pending_sums.push_back(add_f32(a, b));
   endfunction

   function void check_sum(logic [31:0] got);
      logic [31:0] want;
      if (pending_sums.size() == 0) begin
         $error("sum_bits: no sum expected, got %h", got);
         errors++;
         return;
      end
      want = pending_sums.pop_front();
      if (got !== want) begin
         $error("sum_bits: expected %h, got %h", want, got);
         errors++;
      end
   endfunction
endclass

module tb_float32_adder_core;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_a_bits = '0;
   logic [31:0] req_b_bits = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_sum_bits;

   // idling is switched off for a quiet stretch in the middle of the run
   bit quiet = 1'b0;
   sum_scoreboard board = new();

   float32_adder_core dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // generous limit; a correct run needs well under a tenth of this
   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side: random stalls, check on every transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_sum(rsp_sum_bits);
      rsp_ready <= quiet || ($urandom_range(99) >= 6);
   end

   // present one operand pair after an optional random gap, hold until transfer
   task automatic send_pair(logic [31:0] a, logic [31:0] b);
      while (!quiet && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_a_bits <= a;
      req_b_bits <= b;
      do @(posedge clock); while (!req_ready);
      board.note_operands(a, b);
   endtask

   // random operand with biased exponents so alignment, cancellation and exponent-extreme corners show up
   function automatic logic [31:0] rand_operand(logic [31:0] other);
      logic [31:0] v;
      v = $urandom();
      case ($urandom_range(5))
         0: v[30:23] = other[30:23];
         1: v[30:23] = 8'(other[30:23] + $urandom_range(30) - 15);
         2: v[30:23] = 8'($urandom_range(3));
         3: v[30:23] = 8'(8'd255 - $urandom_range(3));
         4: v = {~other[31], other[30:0] ^ ($urandom_range(1) ? 31'h0 : 31'h1)};
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      logic [31:0] a, b;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, cancellation, overflow, underflow, denormal and nan fields
      send_pair(32'h00000000, 32'h00000000);
      send_pair(32'hffffffff, 32'hffffffff);
      send_pair(32'h3f800000, 32'hbf800000);   // exact cancellation
      send_pair(32'h7f7fffff, 32'h7f7fffff);   // overflow to infinity
      send_pair(32'hff7fffff, 32'hff000000);   // negative overflow
      send_pair(32'h00800000, 32'h80000000);   // underflow to signed zero
      send_pair(32'h80ffffff, 32'h00800000);
      send_pair(32'h7f800000, 32'h3f800000);   // infinity field as plain exponent
      send_pair(32'h7fc00000, 32'hffc00001);   // nan fields
      send_pair(32'h007fffff, 32'h00000001);   // denormals get a hidden one
      send_pair(32'h4b800000, 32'h3f800000);   // shift of exactly 24
      send_pair(32'h7f000000, 32'h00000001);   // shift capped at 24
      send_pair(32'h3f800001, 32'hbf800000);   // deep normalization
      send_pair(32'hbf800000, 32'h3f800000);   // tie keeps first operand primary
      send_pair(32'h3fffffff, 32'h3fffffff);   // carry out
      send_pair(32'h55555555, 32'haaaaaaaa);
      send_pair(32'haaaaaaaa, 32'h55555555);

      for (int i = 0; i < 2000; i++) begin
         quiet = (i >= 800 && i < 1100);
         a = $urandom();
         b = rand_operand(a);
         if ($urandom_range(1)) send_pair(a, b);
         else send_pair(b, a);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (board.pending_sums.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule

`default_nettype wire

/* filelist.f */
design/f32add_pkg.sv
design/f32add_align.sv
design/f32add_norm.sv
design/float32_adder_core.sv
tb/tb_float32_adder_core.sv
